### sv/flight_deployment_sequencer_defines.svh
// Assertion macros for the flight deployment sequencer checker
`ifndef FLIGHT_DEPLOYMENT_SEQUENCER_DEFINES_SVH
`define FLIGHT_DEPLOYMENT_SEQUENCER_DEFINES_SVH

// next-cycle check, active through reset
`define FDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

// next-cycle check, masked while reset is high
`define FDS_ASSERT_NEXT_RUN(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/fds_pkg.sv
// Shared types, register codes and constants of the flight deployment sequencer
package fds_pkg;

  typedef enum logic [2:0] {
    PH_PAD      = 3'd0,
    PH_FLIGHT   = 3'd1,
    PH_LANDED   = 3'd2,
    PH_SIGNAL   = 3'd3,
    PH_TRIGGER  = 3'd4,
    PH_DEPLOYED = 3'd5
  } phase_t;

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_GROUND_LEVEL  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAUNCH_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAND_HEIGHT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAG_TOLERANCE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_STABLE_LIMIT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_VERIFY_COUNT  = 3'd5;

  localparam int HEIGHT_W = 20;
  localparam int LIMIT_W  = 31;
  localparam int COUNT_W  = 8;
  localparam int AVG_W    = 32;

  localparam logic [HEIGHT_W-1:0] LAUNCH_HEIGHT_RST = 20'd3200;
  localparam logic [HEIGHT_W-1:0] LAND_HEIGHT_RST   = 20'd3200;
  localparam logic [LIMIT_W-1:0]  MAG_TOLERANCE_RST = 31'd1258291;
  localparam logic [LIMIT_W-1:0]  STABLE_LIMIT_RST  = 31'd838861;
  localparam logic [COUNT_W-1:0]  VERIFY_COUNT_RST  = 8'd20;
  localparam logic [AVG_W-1:0]    AVG_RST           = 32'd41943040;
  localparam logic [AVG_W-1:0]    ONE_G_SQ          = 32'd4194304;

  typedef struct packed {
    logic [HEIGHT_W-1:0] launch_height;
    logic [HEIGHT_W-1:0] land_height;
    logic [LIMIT_W-1:0]  mag_tolerance;
    logic [LIMIT_W-1:0]  stable_limit;
    logic [COUNT_W-1:0]  verify_count;
  } cfg_t;

  typedef struct packed {
    logic             launch_ok;
    logic             land_ok;
    logic [AVG_W-1:0] err_sat;
    logic             deploy_signal;
    logic             stability_due;
  } meas_t;

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
    return (c == {COUNT_W{1'b1}}) ? c : c + COUNT_W'(1);
  endfunction

endpackage

### sv/fds_if.sv
// Request channels of the flight deployment sequencer: sensor samples and results
interface fds_sample_if #(
  parameter int ALT_BITS   = 24,
  parameter int ACCEL_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [ALT_BITS-1:0]   altitude;
  logic signed [ACCEL_BITS-1:0] accel_x;
  logic signed [ACCEL_BITS-1:0] accel_y;
  logic signed [ACCEL_BITS-1:0] accel_z;
  logic                         deploy_signal;
  logic                         stability_due;

  modport source (
    output valid, altitude, accel_x, accel_y, accel_z, deploy_signal, stability_due,
    input  ready
  );
  modport sink (
    input  valid, altitude, accel_x, accel_y, accel_z, deploy_signal, stability_due,
    output ready
  );
endinterface

interface fds_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] phase;
  logic       fire;
  logic       led_red;
  logic       led_green;
  logic       led_blue;

  modport source (
    output valid, phase, fire, led_red, led_green, led_blue,
    input  ready
  );
  modport sink (
    input  valid, phase, fire, led_red, led_green, led_blue,
    output ready
  );
endinterface

### sv/fds_regs.sv
// Configuration registers of the flight deployment sequencer
module fds_regs #(
  parameter int ALT_BITS = 24,
  parameter int DATA_W   = 31
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [fds_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [DATA_W-1:0]                wr_data,
  output logic signed [ALT_BITS-1:0]       ground_level,
  output fds_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      ground_level      <= '0;
      cfg.launch_height <= fds_pkg::LAUNCH_HEIGHT_RST;
      cfg.land_height   <= fds_pkg::LAND_HEIGHT_RST;
      cfg.mag_tolerance <= fds_pkg::MAG_TOLERANCE_RST;
      cfg.stable_limit  <= fds_pkg::STABLE_LIMIT_RST;
      cfg.verify_count  <= fds_pkg::VERIFY_COUNT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        fds_pkg::CFG_GROUND_LEVEL:  ground_level <= wr_data[ALT_BITS-1:0];
        fds_pkg::CFG_LAUNCH_HEIGHT: cfg.launch_height <= wr_data[fds_pkg::HEIGHT_W-1:0];
        fds_pkg::CFG_LAND_HEIGHT:   cfg.land_height <= wr_data[fds_pkg::HEIGHT_W-1:0];
        fds_pkg::CFG_MAG_TOLERANCE: cfg.mag_tolerance <= wr_data[fds_pkg::LIMIT_W-1:0];
        fds_pkg::CFG_STABLE_LIMIT:  cfg.stable_limit <= wr_data[fds_pkg::LIMIT_W-1:0];
        fds_pkg::CFG_VERIFY_COUNT:  cfg.verify_count <= wr_data[fds_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### sv/fds_measure.sv
// Sample measurement pipeline: squares and relative altitude, then threshold flags
module fds_measure #(
  parameter int ALT_BITS   = 24,
  parameter int ACCEL_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  fds_sample_if.sink                 sample,
  input  logic signed [ALT_BITS-1:0] ground_level,
  input  fds_pkg::cfg_t              cfg,
  output logic                       meas_valid,
  input  logic                       meas_ready,
  output fds_pkg::meas_t             meas
);

  localparam int SQ_W  = 2 * ACCEL_BITS;
  localparam int MAG_W = SQ_W + 2;
  localparam int ERR_W = (MAG_W > fds_pkg::AVG_W) ? MAG_W : fds_pkg::AVG_W + 1;
  localparam int REL_W = ALT_BITS + 1;
  localparam int CMP_W = (REL_W > fds_pkg::HEIGHT_W + 1) ? REL_W : fds_pkg::HEIGHT_W + 1;

  logic signed [SQ_W-1:0]  px;
  logic signed [SQ_W-1:0]  py;
  logic signed [SQ_W-1:0]  pz;
  logic                    sq_valid;
  logic                    meas_take;
  logic [SQ_W-1:0]         sq_x;
  logic [SQ_W-1:0]         sq_y;
  logic [SQ_W-1:0]         sq_z;
  logic signed [REL_W-1:0] rel;
  logic                    sig;
  logic                    due;
  logic [MAG_W-1:0]        mag;
  logic [MAG_W-1:0]        one_g;
  logic [MAG_W-1:0]        err;
  logic [ERR_W-1:0]        err_wide;
  logic signed [CMP_W-1:0] rel_wide;
  logic signed [CMP_W-1:0] launch_lim;
  logic signed [CMP_W-1:0] land_lim;

  assign meas_take    = !meas_valid || meas_ready;
  assign sample.ready = !sq_valid || meas_take;

  assign px = SQ_W'(sample.accel_x) * SQ_W'(sample.accel_x);
  assign py = SQ_W'(sample.accel_y) * SQ_W'(sample.accel_y);
  assign pz = SQ_W'(sample.accel_z) * SQ_W'(sample.accel_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (sample.ready) begin
      sq_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      sq_x <= $unsigned(px);
      sq_y <= $unsigned(py);
      sq_z <= $unsigned(pz);
      rel  <= {sample.altitude[ALT_BITS-1], sample.altitude}
            - {ground_level[ALT_BITS-1], ground_level};
      sig  <= sample.deploy_signal;
      due  <= sample.stability_due;
    end
  end

  assign mag        = MAG_W'(sq_x) + MAG_W'(sq_y) + MAG_W'(sq_z);
  assign one_g      = MAG_W'(fds_pkg::ONE_G_SQ);
  assign err        = (mag >= one_g) ? mag - one_g : one_g - mag;
  assign err_wide   = ERR_W'(err);
  assign rel_wide   = CMP_W'(rel);
  assign launch_lim = CMP_W'(cfg.launch_height);
  assign land_lim   = CMP_W'(cfg.land_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      meas_valid <= 1'b0;
    end else if (meas_take) begin
      meas_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_valid && meas_take) begin
      meas.launch_ok     <= rel_wide >= launch_lim;
      meas.land_ok       <= (rel_wide <= land_lim)
                         && (err_wide <= ERR_W'(cfg.mag_tolerance));
      meas.err_sat       <= (|err_wide[ERR_W-1:fds_pkg::AVG_W]) ? '1
                                                                 : err_wide[fds_pkg::AVG_W-1:0];
      meas.deploy_signal <= sig;
      meas.stability_due <= due;
    end
  end

endmodule

### sv/fds_phase.sv
// Phase sequencer: confirmation streaks, stability average and the result register
module fds_phase (
  input  logic           clk,
  input  logic           rst,
  input  logic           meas_valid,
  output logic           meas_ready,
  input  fds_pkg::meas_t meas,
  input  fds_pkg::cfg_t  cfg,
  fds_result_if.source   result
);

  fds_pkg::phase_t                 phase;
  fds_pkg::phase_t                 phase_next;
  logic [fds_pkg::COUNT_W-1:0]     launch_streak;
  logic [fds_pkg::COUNT_W-1:0]     launch_streak_next;
  logic [fds_pkg::COUNT_W-1:0]     land_streak;
  logic [fds_pkg::COUNT_W-1:0]     land_streak_next;
  logic [fds_pkg::COUNT_W-1:0]     signal_streak;
  logic [fds_pkg::COUNT_W-1:0]     signal_streak_next;
  logic [fds_pkg::AVG_W-1:0]       avg;
  logic [fds_pkg::AVG_W-1:0]       avg_next;
  logic [fds_pkg::COUNT_W-1:0]     launch_bump;
  logic [fds_pkg::COUNT_W-1:0]     land_bump;
  logic [fds_pkg::COUNT_W-1:0]     signal_bump;
  logic [fds_pkg::AVG_W:0]         avg_sum;
  logic [fds_pkg::AVG_W-1:0]       avg_half;
  logic                            take;
  fds_pkg::phase_t                 res_phase;
  logic                            res_fire;
  logic                            res_red;
  logic                            res_green;
  logic                            res_blue;

  assign meas_ready  = !result.valid || result.ready;
  assign take        = meas_valid && meas_ready;
  assign launch_bump = fds_pkg::bump(launch_streak);
  assign land_bump   = fds_pkg::bump(land_streak);
  assign signal_bump = fds_pkg::bump(signal_streak);
  assign avg_sum     = {1'b0, avg} + {1'b0, meas.err_sat};
  assign avg_half    = avg_sum[fds_pkg::AVG_W:1];

  always_comb begin
    phase_next         = phase;
    launch_streak_next = launch_streak;
    land_streak_next   = land_streak;
    signal_streak_next = signal_streak;
    avg_next           = avg;
    unique case (phase)
      fds_pkg::PH_PAD: begin
        if (meas.launch_ok) begin
          launch_streak_next = launch_bump;
          if (launch_bump >= cfg.verify_count) phase_next = fds_pkg::PH_FLIGHT;
        end else begin
          launch_streak_next = '0;
        end
      end
      fds_pkg::PH_FLIGHT: begin
        if (meas.land_ok) begin
          land_streak_next = land_bump;
          if (land_bump >= cfg.verify_count) phase_next = fds_pkg::PH_LANDED;
        end else begin
          land_streak_next = '0;
        end
      end
      fds_pkg::PH_LANDED: begin
        signal_streak_next = '0;
        if (meas.deploy_signal) begin
          if (meas.land_ok) begin
            land_streak_next = land_bump;
            if (land_bump >= cfg.verify_count) begin
              signal_streak_next = signal_bump;
              if (signal_bump >= cfg.verify_count) phase_next = fds_pkg::PH_SIGNAL;
            end
          end else begin
            land_streak_next = '0;
          end
        end
      end
      fds_pkg::PH_SIGNAL: begin
        if (meas.stability_due) begin
          avg_next = avg_half;
          if (avg_half < fds_pkg::AVG_W'(cfg.stable_limit)) phase_next = fds_pkg::PH_TRIGGER;
        end
      end
      default: phase_next = fds_pkg::PH_DEPLOYED;
    endcase
  end

  always_comb begin
    res_fire = 1'b0;
    unique case (phase)
      fds_pkg::PH_PAD: begin
        res_phase = fds_pkg::PH_PAD;
        res_red   = meas.deploy_signal;
        res_green = 1'b0;
        res_blue  = 1'b1;
      end
      fds_pkg::PH_FLIGHT: begin
        res_phase = fds_pkg::PH_FLIGHT;
        res_red   = 1'b1;
        res_green = 1'b0;
        res_blue  = 1'b0;
      end
      fds_pkg::PH_LANDED: begin
        res_phase = fds_pkg::PH_LANDED;
        res_red   = 1'b0;
        res_green = 1'b1;
        res_blue  = 1'b0;
      end
      fds_pkg::PH_SIGNAL: begin
        res_phase = fds_pkg::PH_SIGNAL;
        res_red   = 1'b0;
        res_green = 1'b1;
        res_blue  = 1'b1;
      end
      fds_pkg::PH_TRIGGER: begin
        res_phase = fds_pkg::PH_TRIGGER;
        res_fire  = 1'b1;
        res_red   = 1'b1;
        res_green = 1'b0;
        res_blue  = 1'b1;
      end
      default: begin
        res_phase = fds_pkg::PH_DEPLOYED;
        res_red   = 1'b1;
        res_green = 1'b1;
        res_blue  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= fds_pkg::PH_PAD;
      launch_streak <= '0;
      land_streak   <= '0;
      signal_streak <= '0;
      avg           <= fds_pkg::AVG_RST;
    end else if (take) begin
      phase         <= phase_next;
      launch_streak <= launch_streak_next;
      land_streak   <= land_streak_next;
      signal_streak <= signal_streak_next;
      avg           <= avg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (meas_ready) begin
      result.valid <= meas_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.phase     <= res_phase;
      result.fire      <= res_fire;
      result.led_red   <= res_red;
      result.led_green <= res_green;
      result.led_blue  <= res_blue;
    end
  end

endmodule

### sv/flight_deployment_sequencer.sv
// Flight deployment sequencer: sample channel in, one result per sample out.
// sample: altitude, three acceleration axes, deploy line and stability flag.
// result: phase in which the sample was handled, fire pulse, three LED bits.
// wr_en / wr_index / wr_data write the six thresholds; write only while idle.
// Pipeline: a sample accepted on sample.valid && sample.ready passes three register
// stages (squares, threshold flags, result register) before its result is valid.
// Throughput: one sample per cycle while result.ready is high; the only loop is the
// phase/streak/average state update in the sequencer stage, registered on each take.
// Reset (synchronous, rst high): phase goes to pad, all streaks to zero, the
// stability average to ten g squared, configuration registers to defaults,
// and every stage empties.
// Stall: the result register holds while result.ready is low; the two earlier
// stages keep filling, so sample.ready drops only once all three are full.
module flight_deployment_sequencer #(
  parameter int ALT_BITS   = 24,
  parameter int ACCEL_BITS = 16,
  localparam int CFG_DATA_W = (ALT_BITS > fds_pkg::LIMIT_W) ? ALT_BITS : fds_pkg::LIMIT_W
) (
  input  logic                            clk,
  input  logic                            rst,
  fds_sample_if.sink                      sample,
  fds_result_if.source                    result,
  input  logic                            wr_en,
  input  logic [fds_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]           wr_data
);

  logic signed [ALT_BITS-1:0] ground_level;
  fds_pkg::cfg_t              cfg;
  logic                       meas_valid;
  logic                       meas_ready;
  fds_pkg::meas_t             meas;

  fds_regs #(
    .ALT_BITS (ALT_BITS),
    .DATA_W   (CFG_DATA_W)
  ) u_regs (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .ground_level (ground_level),
    .cfg          (cfg)
  );

  fds_measure #(
    .ALT_BITS   (ALT_BITS),
    .ACCEL_BITS (ACCEL_BITS)
  ) u_measure (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .ground_level (ground_level),
    .cfg          (cfg),
    .meas_valid   (meas_valid),
    .meas_ready   (meas_ready),
    .meas         (meas)
  );

  fds_phase u_phase (
    .clk        (clk),
    .rst        (rst),
    .meas_valid (meas_valid),
    .meas_ready (meas_ready),
    .meas       (meas),
    .cfg        (cfg),
    .result     (result)
  );

endmodule

### sv/fds_checker.sv
// Port-level assertions for the flight deployment sequencer, bound to the top level
`include "flight_deployment_sequencer_defines.svh"

module fds_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [2:0] res_phase,
  input logic       res_fire,
  input logic       res_red,
  input logic       res_green,
  input logic       res_blue
);

  logic       res_fired;
  logic       res_stall;
  logic       res_deployed;
  logic [6:0] res_word;

  assign res_fired    = res_valid && res_ready && res_fire;
  assign res_stall    = res_valid && !res_ready;
  assign res_deployed = (res_phase == fds_pkg::PH_DEPLOYED);
  assign res_word     = {res_phase, res_fire, res_red, res_green, res_blue};

  `FDS_ASSERT_NEXT(a_reset_latency, rst, !res_valid ##1 !res_valid, "early result after reset")

  `FDS_ASSERT_NEXT(a_fire_deployed, res_fired, !res_valid || res_deployed, "bad phase after fire")

  `FDS_ASSERT_NEXT_RUN(a_result_hold, res_stall, res_valid && $stable(res_word), "result changed")

endmodule

bind flight_deployment_sequencer fds_checker u_fds_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_phase (result.phase),
  .res_fire  (result.fire),
  .res_red   (result.led_red),
  .res_green (result.led_green),
  .res_blue  (result.led_blue)
);

### bench/testbench.sv
// Self-checking bench for the flight deployment sequencer against a phase predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ALT_W = 24;
  localparam int ACC_W = 16;
  localparam int DATA_W = 31;
  localparam int ACC_MAX = 24576;
  localparam int ONE_G = 2048;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX = 10;
  localparam int ITEM_TARGET = 400;
  localparam logic [fds_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [fds_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam longint ALT_MIN = -(longint'(1) <<< (ALT_W - 1));
  localparam longint ALT_MAX = (longint'(1) <<< (ALT_W - 1)) - 1;
  localparam logic [fds_pkg::HEIGHT_W-1:0] HEIGHT_MAX = '1;
  localparam logic [fds_pkg::LIMIT_W-1:0] LIMIT_MAX = '1;
  localparam logic [fds_pkg::COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [ALT_W-1:0] altitude;
    logic [ACC_W-1:0] accel_x;
    logic [ACC_W-1:0] accel_y;
    logic [ACC_W-1:0] accel_z;
    logic             deploy_signal;
    logic             stability_due;
  } sample_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       fire;
    logic       led_red;
    logic       led_green;
    logic       led_blue;
  } status_t;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [fds_pkg::CFG_INDEX_W-1:0] wr_index;
  logic [DATA_W-1:0] wr_data;

  fds_sample_if #(.ALT_BITS(ALT_W), .ACCEL_BITS(ACC_W)) sample_ch ();
  fds_result_if result_ch ();

  flight_deployment_sequencer #(.ALT_BITS(ALT_W), .ACCEL_BITS(ACC_W)) u_top (
    .clk(clk),
    .rst(rst),
    .sample(sample_ch),
    .result(result_ch),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  logic signed [ALT_W-1:0] ground_ref;
  logic [fds_pkg::HEIGHT_W-1:0] launch_h;
  logic [fds_pkg::HEIGHT_W-1:0] land_h;
  logic [fds_pkg::LIMIT_W-1:0] accel_tol;
  logic [fds_pkg::LIMIT_W-1:0] stable_lim;
  logic [fds_pkg::COUNT_W-1:0] confirm_n;
  fds_pkg::phase_t ph;
  logic [fds_pkg::COUNT_W-1:0] launch_run;
  logic [fds_pkg::COUNT_W-1:0] land_run;
  logic [fds_pkg::COUNT_W-1:0] signal_run;
  logic [fds_pkg::AVG_W-1:0] avg_err;

  status_t status_q[$];
  int mismatch_count = 0;
  int sent_items = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stalled_cycles = 0;

  always #5 clk = ~clk;

  function automatic logic [fds_pkg::COUNT_W-1:0] run_inc(
      input logic [fds_pkg::COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
  endfunction

  function automatic bit land_passes(input longint rel, input longint err);
    if (rel > longint'(land_h) || err > longint'(accel_tol)) begin
      land_run = '0;
      return 1'b0;
    end
    land_run = run_inc(land_run);
    return land_run >= confirm_n;
  endfunction

  function automatic status_t advance_sequence(input sample_t s);
    longint rel;
    longint ax;
    longint ay;
    longint az;
    longint mag;
    longint err;
    longint sat;
    status_t st;
    rel = longint'($signed(s.altitude)) - longint'(ground_ref);
    ax = longint'($signed(s.accel_x));
    ay = longint'($signed(s.accel_y));
    az = longint'($signed(s.accel_z));
    mag = ax * ax + ay * ay + az * az;
    err = (mag >= longint'(fds_pkg::ONE_G_SQ)) ? mag - longint'(fds_pkg::ONE_G_SQ)
                                               : longint'(fds_pkg::ONE_G_SQ) - mag;
    st.phase = ph;
    st.fire = 1'b0;
    case (ph)
      fds_pkg::PH_PAD: begin
        {st.led_red, st.led_green, st.led_blue} = {s.deploy_signal, 2'b01};
        if (rel < longint'(launch_h)) begin
          launch_run = '0;
        end else begin
          launch_run = run_inc(launch_run);
          if (launch_run >= confirm_n) ph = fds_pkg::PH_FLIGHT;
        end
      end
      fds_pkg::PH_FLIGHT: begin
        {st.led_red, st.led_green, st.led_blue} = 3'b100;
        if (land_passes(rel, err)) ph = fds_pkg::PH_LANDED;
      end
      fds_pkg::PH_LANDED: begin
        {st.led_red, st.led_green, st.led_blue} = 3'b010;
        if (s.deploy_signal && land_passes(rel, err)) begin
          signal_run = run_inc(signal_run);
          if (signal_run >= confirm_n) ph = fds_pkg::PH_SIGNAL;
        end else begin
          signal_run = '0;
        end
      end
      fds_pkg::PH_SIGNAL: begin
        {st.led_red, st.led_green, st.led_blue} = 3'b011;
        if (s.stability_due) begin
          sat = (err > longint'(32'hFFFF_FFFF)) ? longint'(32'hFFFF_FFFF) : err;
          avg_err = fds_pkg::AVG_W'((longint'(avg_err) + sat) >> 1);
          if (avg_err < stable_lim) ph = fds_pkg::PH_TRIGGER;
        end
      end
      fds_pkg::PH_TRIGGER: begin
        {st.led_red, st.led_green, st.led_blue} = 3'b101;
        st.fire = 1'b1;
        ph = fds_pkg::PH_DEPLOYED;
      end
      default: begin
        {st.led_red, st.led_green, st.led_blue} = 3'b111;
        st.phase = fds_pkg::PH_DEPLOYED;
        ph = fds_pkg::PH_DEPLOYED;
      end
    endcase
    return st;
  endfunction

  function automatic int spread(input int n);
    return int'($urandom_range(2 * n)) - n;
  endfunction

  function automatic sample_t build_sample(input longint rel, input bit at_rest,
                                           input bit sig, input bit due);
    sample_t s;
    longint alt;
    int ax;
    int ay;
    int az;
    int g;
    alt = longint'(ground_ref) + rel;
    if (alt < ALT_MIN) alt = ALT_MIN;
    if (alt > ALT_MAX) alt = ALT_MAX;
    if (at_rest) begin
      ax = spread(60);
      ay = spread(60);
      az = spread(60);
      g = $urandom_range(1) ? ONE_G + spread(60) : -ONE_G + spread(60);
      case ($urandom_range(2))
        0: ax = g;
        1: ay = g;
        default: az = g;
      endcase
    end else begin
      ax = spread(ACC_MAX);
      ay = spread(ACC_MAX);
      az = spread(ACC_MAX);
    end
    s.altitude = ALT_W'(alt);
    s.accel_x = ACC_W'(ax);
    s.accel_y = ACC_W'(ay);
    s.accel_z = ACC_W'(az);
    s.deploy_signal = sig;
    s.stability_due = due;
    return s;
  endfunction

  task automatic reset_predictor();
    ground_ref = '0;
    launch_h = fds_pkg::LAUNCH_HEIGHT_RST;
    land_h = fds_pkg::LAND_HEIGHT_RST;
    accel_tol = fds_pkg::MAG_TOLERANCE_RST;
    stable_lim = fds_pkg::STABLE_LIMIT_RST;
    confirm_n = fds_pkg::VERIFY_COUNT_RST;
    ph = fds_pkg::PH_PAD;
    launch_run = '0;
    land_run = '0;
    signal_run = '0;
    avg_err = fds_pkg::AVG_RST;
  endtask

  task automatic put_config(input logic [fds_pkg::CFG_INDEX_W-1:0] idx,
                            input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] data;
    data = DATA_W'($urandom());
    case (idx)
      fds_pkg::CFG_GROUND_LEVEL: begin
        data[ALT_W-1:0] = value[ALT_W-1:0];
        ground_ref = value[ALT_W-1:0];
      end
      fds_pkg::CFG_LAUNCH_HEIGHT: begin
        data[fds_pkg::HEIGHT_W-1:0] = value[fds_pkg::HEIGHT_W-1:0];
        launch_h = value[fds_pkg::HEIGHT_W-1:0];
      end
      fds_pkg::CFG_LAND_HEIGHT: begin
        data[fds_pkg::HEIGHT_W-1:0] = value[fds_pkg::HEIGHT_W-1:0];
        land_h = value[fds_pkg::HEIGHT_W-1:0];
      end
      fds_pkg::CFG_MAG_TOLERANCE: begin
        data = value;
        accel_tol = value[fds_pkg::LIMIT_W-1:0];
      end
      fds_pkg::CFG_STABLE_LIMIT: begin
        data = value;
        stable_lim = value[fds_pkg::LIMIT_W-1:0];
      end
      fds_pkg::CFG_VERIFY_COUNT: begin
        data[fds_pkg::COUNT_W-1:0] = value[fds_pkg::COUNT_W-1:0];
        confirm_n = value[fds_pkg::COUNT_W-1:0];
      end
      default: begin
        data = value;
      end
    endcase
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic send_sample(input sample_t s);
    if (sent_items < ITEM_TARGET / 3) begin
      send_idle_pct = 28;
      recv_idle_pct = 48;
    end else if (sent_items < 2 * ITEM_TARGET / 3) begin
      send_idle_pct = 48;
      recv_idle_pct = 28;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.altitude <= s.altitude;
    sample_ch.accel_x <= s.accel_x;
    sample_ch.accel_y <= s.accel_y;
    sample_ch.accel_z <= s.accel_z;
    sample_ch.deploy_signal <= s.deploy_signal;
    sample_ch.stability_due <= s.stability_due;
    do @(posedge clk); while (!sample_ch.ready);
    status_q.push_back(advance_sequence(s));
    sent_items++;
  endtask

  task automatic settle();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_register_extremes();
    sample_t s;
    put_config(fds_pkg::CFG_GROUND_LEVEL, DATA_W'(ALT_MAX));
    put_config(fds_pkg::CFG_LAUNCH_HEIGHT, DATA_W'(HEIGHT_MAX));
    put_config(fds_pkg::CFG_LAND_HEIGHT, '0);
    put_config(fds_pkg::CFG_MAG_TOLERANCE, DATA_W'(LIMIT_MAX));
    put_config(fds_pkg::CFG_STABLE_LIMIT, '0);
    put_config(fds_pkg::CFG_VERIFY_COUNT, DATA_W'(COUNT_MAX));
    put_config(CFG_SPARE_LO, DATA_W'($urandom()));
    put_config(CFG_SPARE_HI, DATA_W'($urandom()));
    for (int i = 0; i < 8; i++) begin
      s = build_sample(0, 1'b0, i[1], i[2]);
      s.altitude = i[0] ? ALT_W'(ALT_MAX) : ALT_W'(ALT_MIN);
      s.accel_x = i[1] ? ACC_W'(ACC_MAX) : ACC_W'(-ACC_MAX);
      s.accel_y = i[1] ? ACC_W'(-ACC_MAX) : ACC_W'(ACC_MAX);
      s.accel_z = i[2] ? ACC_W'(0) : ACC_W'(ACC_MAX);
      send_sample(s);
    end
    settle();
    put_config(fds_pkg::CFG_GROUND_LEVEL, DATA_W'(ALT_MIN));
    put_config(fds_pkg::CFG_LAUNCH_HEIGHT, '0);
    for (int i = 0; i < 4; i++) begin
      s = build_sample(0, 1'b0, i[0], i[1]);
      s.altitude = i[1] ? ALT_W'(ALT_MAX) : ALT_W'(ALT_MIN);
      if (i == 3) begin
        s.accel_x = '0;
        s.accel_y = '0;
        s.accel_z = '0;
      end
      send_sample(s);
    end
  endtask

  task automatic test_pad_noise();
    longint rel;
    settle();
    put_config(fds_pkg::CFG_GROUND_LEVEL, DATA_W'(spread(1 << 20)));
    put_config(fds_pkg::CFG_LAUNCH_HEIGHT, DATA_W'($urandom_range(100000, 1000)));
    for (int i = 0; i < 100; i++) begin
      if ($urandom_range(99) < 60) rel = longint'(launch_h) + $urandom_range(20000);
      else rel = longint'(launch_h) - 1 - $urandom_range(20000);
      send_sample(build_sample(rel, $urandom_range(1), $urandom_range(1), $urandom_range(1)));
    end
  endtask

  task automatic test_launch();
    int n;
    settle();
    put_config(fds_pkg::CFG_VERIFY_COUNT, DATA_W'($urandom_range(8, 2)));
    for (int run = 0; run < 3; run++) begin
      send_sample(build_sample(longint'(launch_h) - 1, $urandom_range(1), $urandom_range(1),
                               $urandom_range(1)));
      repeat ($urandom_range(confirm_n - 1))
        send_sample(build_sample(longint'(launch_h) + $urandom_range(5000), $urandom_range(1),
                                 $urandom_range(1), $urandom_range(1)));
    end
    n = 0;
    while (ph == fds_pkg::PH_PAD && n < 300) begin
      send_sample(build_sample(longint'(launch_h) + ((n == 0) ? 0 : $urandom_range(50000)),
                               $urandom_range(1), $urandom_range(1), $urandom_range(1)));
      n++;
    end
  endtask

  task automatic test_flight_and_landing();
    longint rel;
    int n;
    settle();
    put_config(fds_pkg::CFG_VERIFY_COUNT, DATA_W'(COUNT_MAX));
    put_config(fds_pkg::CFG_LAND_HEIGHT, DATA_W'($urandom_range(50000, 100)));
    put_config(fds_pkg::CFG_MAG_TOLERANCE, DATA_W'($urandom_range(3000000, 500000)));
    for (int i = 0; i < 50; i++) begin
      if ($urandom_range(99) < 50) rel = longint'(land_h) - $urandom_range(20000);
      else rel = longint'(land_h) + 1 + $urandom_range(100000);
      send_sample(build_sample(rel, $urandom_range(99) < 60, $urandom_range(1),
                               $urandom_range(1)));
    end
    settle();
    put_config(fds_pkg::CFG_VERIFY_COUNT, '0);
    put_config(fds_pkg::CFG_LAND_HEIGHT, DATA_W'(HEIGHT_MAX));
    n = 0;
    while (ph == fds_pkg::PH_FLIGHT && n < 50) begin
      send_sample(build_sample(spread(1000), 1'b1, $urandom_range(1), $urandom_range(1)));
      n++;
    end
  endtask

  task automatic test_landed_signal();
    sample_t s;
    longint rel;
    int n;
    settle();
    put_config(fds_pkg::CFG_VERIFY_COUNT, DATA_W'(COUNT_MAX));
    put_config(fds_pkg::CFG_LAND_HEIGHT, DATA_W'($urandom_range(50000, 100)));
    put_config(fds_pkg::CFG_MAG_TOLERANCE, DATA_W'(fds_pkg::MAG_TOLERANCE_RST));
    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(99) < 60) rel = longint'(land_h) - $urandom_range(20000);
      else rel = longint'(land_h) + 1 + $urandom_range(20000);
      send_sample(build_sample(rel, $urandom_range(99) < 70, $urandom_range(99) < 70,
                               $urandom_range(1)));
    end
    settle();
    put_config(fds_pkg::CFG_MAG_TOLERANCE, '0);
    put_config(fds_pkg::CFG_LAND_HEIGHT, '0);
    for (int i = 0; i < 8; i++) begin
      s = build_sample(i[0] ? 0 : 1, 1'b1, 1'b1, i[2]);
      if (i[1]) begin
        s.accel_x = '0;
        s.accel_y = '0;
        s.accel_z = i[2] ? ACC_W'(ONE_G) : ACC_W'(-ONE_G);
      end
      send_sample(s);
    end
    settle();
    put_config(fds_pkg::CFG_VERIFY_COUNT, DATA_W'($urandom_range(8, 2)));
    put_config(fds_pkg::CFG_MAG_TOLERANCE, DATA_W'(fds_pkg::MAG_TOLERANCE_RST));
    put_config(fds_pkg::CFG_LAND_HEIGHT, DATA_W'($urandom_range(50000, 100)));
    // leave the landing streak ahead of the signal streak so it saturates first
    send_sample(build_sample(0, 1'b1, 1'b1, $urandom_range(1)));
    send_sample(build_sample(0, 1'b1, 1'b0, $urandom_range(1)));
    n = 0;
    while (ph == fds_pkg::PH_LANDED && n < 300) begin
      send_sample(build_sample(longint'($urandom_range(land_h)) - 2000, 1'b1, 1'b1,
                               $urandom_range(1)));
      n++;
    end
  endtask

  task automatic test_stability();
    int n;
    settle();
    put_config(fds_pkg::CFG_STABLE_LIMIT, '0);
    for (int i = 0; i < 30; i++)
      send_sample(build_sample(spread(100000), $urandom_range(1), $urandom_range(1),
                               $urandom_range(1)));
    settle();
    put_config(fds_pkg::CFG_STABLE_LIMIT, DATA_W'($urandom_range(2000000, 600000)));
    n = 0;
    while (ph == fds_pkg::PH_SIGNAL && n < 200) begin
      send_sample(build_sample(spread(5000), 1'b1, $urandom_range(1), $urandom_range(99) < 70));
      n++;
    end
  endtask

  task automatic test_trigger_and_deployed();
    sample_t s;
    int n;
    n = 0;
    while (ph == fds_pkg::PH_TRIGGER && n < 4) begin
      send_sample(build_sample(spread(5000), $urandom_range(1), $urandom_range(1),
                               $urandom_range(1)));
      n++;
    end
    for (int i = 0; i < 64; i++) begin
      if (i == 32) begin
        settle();
        put_config(fds_pkg::CFG_STABLE_LIMIT, DATA_W'(LIMIT_MAX));
        put_config(fds_pkg::CFG_MAG_TOLERANCE, DATA_W'($urandom_range(4000000)));
        put_config(fds_pkg::CFG_GROUND_LEVEL, DATA_W'(spread(1 << 22)));
        put_config(fds_pkg::CFG_LAUNCH_HEIGHT, DATA_W'($urandom_range(HEIGHT_MAX)));
      end
      s = build_sample(0, $urandom_range(1), $urandom_range(1), $urandom_range(1));
      s.altitude = ALT_W'($urandom());
      send_sample(s);
    end
  endtask

  always @(negedge clk)
    result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    status_t exp_st;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (status_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected status: phase %0d fire %b led %b%b%b", result_ch.phase,
                   result_ch.fire, result_ch.led_red, result_ch.led_green, result_ch.led_blue);
      end else begin
        exp_st = status_q.pop_front();
        if (result_ch.phase !== exp_st.phase || result_ch.fire !== exp_st.fire ||
            result_ch.led_red !== exp_st.led_red || result_ch.led_green !== exp_st.led_green ||
            result_ch.led_blue !== exp_st.led_blue) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display({"status mismatch: expected phase %0d fire %b led %b%b%b, ",
                      "got phase %0d fire %b led %b%b%b"},
                     exp_st.phase, exp_st.fire, exp_st.led_red, exp_st.led_green,
                     exp_st.led_blue, result_ch.phase, result_ch.fire, result_ch.led_red,
                     result_ch.led_green, result_ch.led_blue);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.altitude = '0;
    sample_ch.accel_x = '0;
    sample_ch.accel_y = '0;
    sample_ch.accel_z = '0;
    sample_ch.deploy_signal = 1'b0;
    sample_ch.stability_due = 1'b0;
    reset_predictor();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_register_extremes();
    test_pad_noise();
    test_launch();
    test_flight_and_landing();
    test_landed_signal();
    test_stability();
    test_trigger_and_deployed();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && status_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/fds_pkg.sv
sv/fds_if.sv
sv/fds_regs.sv
sv/fds_measure.sv
sv/fds_phase.sv
sv/flight_deployment_sequencer.sv
sv/fds_checker.sv
bench/testbench.sv
